FILE: design/pds_pkg.sv
// shared constants and register codes for the pid drive step block
package pds_pkg;

   localparam int GAIN_WIDTH     = 16;
   localparam int TICK_WIDTH     = 16;
   localparam int DRIVE_WIDTH    = 32;
   localparam int CSR_ADDR_WIDTH = 4;
   localparam int CSR_DATA_WIDTH = 32;

   typedef enum logic [1:0] {
      REG_P_GAIN = 2'd0,
      REG_I_GAIN = 2'd1,
      REG_D_GAIN = 2'd2
   } csr_reg_type;

endpackage

FILE: design/pid_drive_step.sv
// pid controller with variable time step, bit-serial multiply and divide
//
// One word is taken at a time. Each word runs through a bit-serial shift-add
// multiplier three times (proportional, integral and derivative products, one
// gain bit per cycle), with the error-times-ticks product done alongside the
// first pass and a restoring divider (one quotient bit per cycle) started at
// acceptance running under the first two passes. The next input word can be
// taken in the same cycle as the result word is presented; a waiting result
// does not block the next input word until the new result is ready to be
// written to the output register. Gains are written through the csr port at
// byte addresses 0, 4 and 8 (proportional, integral, derivative) and read
// back zero-extended.
module pid_drive_step
   import pds_pkg::*;
#(
   parameter int SAMPLE_WIDTH   = 16,
   parameter int GAIN_FRAC_BITS = 8,
   parameter int INTEGRAL_WIDTH = 40
) (
   input  logic                             clock,
   input  logic                             reset,

   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic signed [SAMPLE_WIDTH-1:0]   req_target,
   input  logic signed [SAMPLE_WIDTH-1:0]   req_measured,
   input  logic        [TICK_WIDTH-1:0]     req_elapsed_ticks,

   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic signed [DRIVE_WIDTH-1:0]    rsp_drive,
   output logic                             rsp_clipped,

   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic        [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic        [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic        [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                             csr_pready
);

   localparam int SW     = SAMPLE_WIDTH;
   localparam int F      = GAIN_FRAC_BITS;
   localparam int IW     = INTEGRAL_WIDTH;
   localparam int ERR_W  = SW + 1;
   localparam int DIF_W  = SW + 2;
   localparam int ITP_W  = ERR_W + TICK_WIDTH;
   localparam int SUM_W  = ((IW > ITP_W) ? IW : ITP_W) + 1;
   localparam int DQ_W   = SW + 1 + F;
   localparam int DER_W  = DQ_W + 1;
   localparam int D_W    = GAIN_WIDTH + DER_W;
   localparam int DS_W   = D_W - F;
   localparam int P_W    = GAIN_WIDTH + ERR_W;
   localparam int I_W    = GAIN_WIDTH + IW;
   localparam int M1_W   = (P_W > I_W) ? P_W : I_W;
   localparam int M2_W   = (M1_W > DS_W) ? M1_W : DS_W;
   localparam int M3_W   = (M2_W > DRIVE_WIDTH + F) ? M2_W : DRIVE_WIDTH + F;
   localparam int ACC_W  = M3_W + 2;
   localparam int CW     = ACC_W - F;
   localparam int DCNT_W = $clog2(DQ_W + 1);
   localparam int STEP_W = $clog2(GAIN_WIDTH);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL1,
      ST_ITG,
      ST_MUL2,
      ST_DWAIT,
      ST_MUL3,
      ST_SUM,
      ST_DONE
   } state_type;

   state_type               state_ff, state_in;
   logic [STEP_W-1:0]       step_cnt_ff, step_cnt_in;

   logic [ITP_W-1:0]        itp_ff, itp_in;
   logic [ITP_W-1:0]        itpa_ff, itpa_in;
   logic [TICK_WIDTH-1:0]   tsh_ff, tsh_in;

   logic [ACC_W-1:0]        mac_ff, mac_in;
   logic [ACC_W-1:0]        mca_ff, mca_in;
   logic [GAIN_WIDTH-1:0]   gsh_ff, gsh_in;
   logic [D_W-1:0]          dac_ff, dac_in;
   logic [D_W-1:0]          dca_ff, dca_in;

   logic [TICK_WIDTH-1:0]   rem_ff, rem_in;
   logic [TICK_WIDTH-1:0]   dvs_ff, dvs_in;
   logic [DQ_W-1:0]         num_ff, num_in;
   logic [DCNT_W-1:0]       div_cnt_ff, div_cnt_in;
   logic                    div_busy_ff, div_busy_in;
   logic                    div_neg_ff, div_neg_in;

   logic [IW-1:0]           integral_ff, integral_in;
   logic [ERR_W-1:0]        prev_err_ff, prev_err_in;
   logic                    clip_ff, clip_in;

   logic [GAIN_WIDTH-1:0]   p_gain_ff, p_gain_in;
   logic [GAIN_WIDTH-1:0]   i_gain_ff, i_gain_in;
   logic [GAIN_WIDTH-1:0]   d_gain_ff, d_gain_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [DRIVE_WIDTH-1:0]  rsp_drive_ff, rsp_drive_in;
   logic                    rsp_clipped_ff, rsp_clipped_in;

   logic                    req_take;
   logic                    csr_write;
   logic                    last_step;
   logic [ERR_W-1:0]        err_c;
   logic [DIF_W-1:0]        diff_c;
   logic [DIF_W-1:0]        diff_abs;
   logic [TICK_WIDTH-1:0]   ticks_eff;
   logic [TICK_WIDTH:0]     rem_shift;
   logic [TICK_WIDTH:0]     trial;
   logic                    take_bit;
   logic [DER_W-1:0]        deriv_c;
   logic [SUM_W-1:0]        itg_sum;
   logic [SUM_W-IW:0]       itg_hi;
   logic                    itg_ovf;
   logic [DS_W-1:0]         dshift;
   logic [CW-1:0]           acc_shift;
   logic [CW-DRIVE_WIDTH:0] acc_hi;
   logic                    drv_ovf;
   logic [DRIVE_WIDTH-1:0]  drv_c;

   assign req_ready   = (state_ff == ST_IDLE);
   assign req_take    = req_valid && req_ready;
   assign csr_write   = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready  = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_drive   = rsp_drive_ff;
   assign rsp_clipped = rsp_clipped_ff;
   assign last_step   = (step_cnt_ff == STEP_W'(GAIN_WIDTH - 1));

   // error, derivative numerator and divisor at acceptance
   assign err_c     = {req_target[SW-1], req_target} - {req_measured[SW-1], req_measured};
   assign diff_c    = {err_c[ERR_W-1], err_c} - {prev_err_ff[ERR_W-1], prev_err_ff};
   assign diff_abs  = diff_c[DIF_W-1] ? (~diff_c + DIF_W'(1)) : diff_c;
   assign ticks_eff = (req_elapsed_ticks == '0) ? TICK_WIDTH'(1) : req_elapsed_ticks;

   // restoring divider step
   assign rem_shift = {rem_ff, num_ff[DQ_W-1]};
   assign trial     = rem_shift - {1'b0, dvs_ff};
   assign take_bit  = ~trial[TICK_WIDTH];
   assign deriv_c   = div_neg_ff ? (~{1'b0, num_ff} + DER_W'(1)) : {1'b0, num_ff};

   // integral update with saturation
   assign itg_sum = {{(SUM_W-IW){integral_ff[IW-1]}}, integral_ff}
                  + {{(SUM_W-ITP_W){itp_ff[ITP_W-1]}}, itp_ff};
   assign itg_hi  = itg_sum[SUM_W-1:IW-1];
   assign itg_ovf = ~((&itg_hi) || ~(|itg_hi));

   // final shift and drive saturation
   assign dshift    = dac_ff[D_W-1:F];
   assign acc_shift = mac_ff[ACC_W-1:F];
   assign acc_hi    = acc_shift[CW-1:DRIVE_WIDTH-1];
   assign drv_ovf   = ~((&acc_hi) || ~(|acc_hi));
   assign drv_c     = drv_ovf ? (acc_shift[CW-1] ? {1'b1, {(DRIVE_WIDTH-1){1'b0}}}
                                                 : {1'b0, {(DRIVE_WIDTH-1){1'b1}}})
                              : acc_shift[DRIVE_WIDTH-1:0];

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_P_GAIN: csr_prdata = CSR_DATA_WIDTH'(p_gain_ff);
         REG_I_GAIN: csr_prdata = CSR_DATA_WIDTH'(i_gain_ff);
         REG_D_GAIN: csr_prdata = CSR_DATA_WIDTH'(d_gain_ff);
         default:    csr_prdata = '0;
      endcase
   end

   always_comb begin
      state_in       = state_ff;
      step_cnt_in    = step_cnt_ff;
      itp_in         = itp_ff;
      itpa_in        = itpa_ff;
      tsh_in         = tsh_ff;
      mac_in         = mac_ff;
      mca_in         = mca_ff;
      gsh_in         = gsh_ff;
      dac_in         = dac_ff;
      dca_in         = dca_ff;
      rem_in         = rem_ff;
      dvs_in         = dvs_ff;
      num_in         = num_ff;
      div_cnt_in     = div_cnt_ff;
      div_busy_in    = div_busy_ff;
      div_neg_in     = div_neg_ff;
      integral_in    = integral_ff;
      prev_err_in    = prev_err_ff;
      clip_in        = clip_ff;
      p_gain_in      = p_gain_ff;
      i_gain_in      = i_gain_ff;
      d_gain_in      = d_gain_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_drive_in   = rsp_drive_ff;
      rsp_clipped_in = rsp_clipped_ff;

      if (csr_write) begin
         unique case (csr_paddr[3:2])
            REG_P_GAIN: p_gain_in = csr_pwdata[GAIN_WIDTH-1:0];
            REG_I_GAIN: i_gain_in = csr_pwdata[GAIN_WIDTH-1:0];
            REG_D_GAIN: d_gain_in = csr_pwdata[GAIN_WIDTH-1:0];
            default: begin
            end
         endcase
      end

      if (div_busy_ff) begin
         rem_in     = take_bit ? trial[TICK_WIDTH-1:0] : rem_shift[TICK_WIDTH-1:0];
         num_in     = {num_ff[DQ_W-2:0], take_bit};
         div_cnt_in = div_cnt_ff + DCNT_W'(1);
         if (div_cnt_ff == DCNT_W'(DQ_W - 1)) begin
            div_busy_in = 1'b0;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               itp_in      = '0;
               itpa_in     = {{(ITP_W-ERR_W){err_c[ERR_W-1]}}, err_c};
               tsh_in      = ticks_eff;
               mac_in      = '0;
               mca_in      = {{(ACC_W-ERR_W){err_c[ERR_W-1]}}, err_c};
               gsh_in      = p_gain_ff;
               step_cnt_in = '0;
               rem_in      = '0;
               dvs_in      = ticks_eff;
               num_in      = DQ_W'(diff_abs[DIF_W-2:0]) << F;
               div_cnt_in  = '0;
               div_busy_in = 1'b1;
               div_neg_in  = diff_c[DIF_W-1];
               prev_err_in = err_c;
               clip_in     = 1'b0;
               state_in    = ST_MUL1;
            end
         end
         ST_MUL1: begin
            if (tsh_ff[0]) begin
               itp_in = itp_ff + itpa_ff;
            end
            itpa_in = itpa_ff << 1;
            tsh_in  = tsh_ff >> 1;
            if (gsh_ff[0]) begin
               mac_in = last_step ? (mac_ff - mca_ff) : (mac_ff + mca_ff);
            end
            mca_in      = mca_ff << 1;
            gsh_in      = gsh_ff >> 1;
            step_cnt_in = step_cnt_ff + STEP_W'(1);
            if (last_step) begin
               state_in = ST_ITG;
            end
         end
         ST_ITG: begin
            if (itg_ovf) begin
               integral_in = itg_sum[SUM_W-1] ? {1'b1, {(IW-1){1'b0}}}
                                              : {1'b0, {(IW-1){1'b1}}};
            end else begin
               integral_in = itg_sum[IW-1:0];
            end
            clip_in     = clip_ff | itg_ovf;
            mca_in      = {{(ACC_W-IW){integral_in[IW-1]}}, integral_in};
            gsh_in      = i_gain_ff;
            step_cnt_in = '0;
            state_in    = ST_MUL2;
         end
         ST_MUL2: begin
            if (gsh_ff[0]) begin
               mac_in = last_step ? (mac_ff - mca_ff) : (mac_ff + mca_ff);
            end
            mca_in      = mca_ff << 1;
            gsh_in      = gsh_ff >> 1;
            step_cnt_in = step_cnt_ff + STEP_W'(1);
            if (last_step) begin
               if (div_busy_ff) begin
                  state_in = ST_DWAIT;
               end else begin
                  dac_in      = '0;
                  dca_in      = {{(D_W-DER_W){deriv_c[DER_W-1]}}, deriv_c};
                  gsh_in      = d_gain_ff;
                  step_cnt_in = '0;
                  state_in    = ST_MUL3;
               end
            end
         end
         ST_DWAIT: begin
            if (!div_busy_ff) begin
               dac_in      = '0;
               dca_in      = {{(D_W-DER_W){deriv_c[DER_W-1]}}, deriv_c};
               gsh_in      = d_gain_ff;
               step_cnt_in = '0;
               state_in    = ST_MUL3;
            end
         end
         ST_MUL3: begin
            if (gsh_ff[0]) begin
               dac_in = last_step ? (dac_ff - dca_ff) : (dac_ff + dca_ff);
            end
            dca_in      = dca_ff << 1;
            gsh_in      = gsh_ff >> 1;
            step_cnt_in = step_cnt_ff + STEP_W'(1);
            if (last_step) begin
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            mac_in   = mac_ff + {{(ACC_W-DS_W){dshift[DS_W-1]}}, dshift};
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_drive_in   = drv_c;
               rsp_clipped_in = clip_ff | drv_ovf;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         div_busy_ff  <= 1'b0;
         integral_ff  <= '0;
         prev_err_ff  <= '0;
         p_gain_ff    <= '0;
         i_gain_ff    <= '0;
         d_gain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         div_busy_ff  <= div_busy_in;
         integral_ff  <= integral_in;
         prev_err_ff  <= prev_err_in;
         p_gain_ff    <= p_gain_in;
         i_gain_ff    <= i_gain_in;
         d_gain_ff    <= d_gain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      step_cnt_ff    <= step_cnt_in;
      itp_ff         <= itp_in;
      itpa_ff        <= itpa_in;
      tsh_ff         <= tsh_in;
      mac_ff         <= mac_in;
      mca_ff         <= mca_in;
      gsh_ff         <= gsh_in;
      dac_ff         <= dac_in;
      dca_ff         <= dca_in;
      rem_ff         <= rem_in;
      dvs_ff         <= dvs_in;
      num_ff         <= num_in;
      div_cnt_ff     <= div_cnt_in;
      div_neg_ff     <= div_neg_in;
      clip_ff        <= clip_in;
      rsp_drive_ff   <= rsp_drive_in;
      rsp_clipped_ff <= rsp_clipped_in;
   end

endmodule

FILE: verif/pid_drive_step_test.sv
// self-checking testbench for the pid drive step block with a built-in drive predictor
`timescale 1ns / 1ps

module pid_drive_step_test
   import pds_pkg::*;
();

   localparam int SAMPLE_BITS      = 16;
   localparam int FRAC_BITS        = 8;
   localparam int INTEG_BITS       = 40;
   localparam int NUM_GAINS        = 3;
   localparam int IDLE_PERCENT     = 17;
   localparam int RSP_HOLD_CYCLES  = 800;
   localparam int RANDOM_PHASES    = 6;
   localparam int WORDS_PER_PHASE  = 130;
   localparam int SETTLE_CYCLES    = 60;
   localparam int SAT_RUN_LEN      = 25;
   localparam int MAX_PRINTED      = 40;
   localparam longint TIMEOUT_NS   = 64'd10_000_000;
   localparam logic [CSR_ADDR_WIDTH-1:0] SPARE_ADDR = CSR_ADDR_WIDTH'(NUM_GAINS * 4);

   typedef struct {
      logic signed [SAMPLE_BITS-1:0] target;
      logic signed [SAMPLE_BITS-1:0] measured;
      logic        [TICK_WIDTH-1:0]  ticks;
   } pid_word_type;

   typedef struct {
      logic signed [DRIVE_WIDTH-1:0] drive;
      logic                          clipped;
   } drive_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                             req_valid         = 1'b0;
   logic                             req_ready;
   logic signed [SAMPLE_BITS-1:0]    req_target        = '0;
   logic signed [SAMPLE_BITS-1:0]    req_measured      = '0;
   logic        [TICK_WIDTH-1:0]     req_elapsed_ticks = '0;

   logic                             rsp_valid;
   logic                             rsp_ready         = 1'b0;
   logic signed [DRIVE_WIDTH-1:0]    rsp_drive;
   logic                             rsp_clipped;

   logic                             csr_psel          = 1'b0;
   logic                             csr_penable       = 1'b0;
   logic                             csr_pwrite        = 1'b0;
   logic        [CSR_ADDR_WIDTH-1:0] csr_paddr         = '0;
   logic        [CSR_DATA_WIDTH-1:0] csr_pwdata        = '0;
   logic        [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic                             csr_pready;

   pid_drive_step #(
      .SAMPLE_WIDTH   (SAMPLE_BITS),
      .GAIN_FRAC_BITS (FRAC_BITS),
      .INTEGRAL_WIDTH (INTEG_BITS)
   ) i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_target        (req_target),
      .req_measured      (req_measured),
      .req_elapsed_ticks (req_elapsed_ticks),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_drive         (rsp_drive),
      .rsp_clipped       (rsp_clipped),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // predictor state
   logic signed [GAIN_WIDTH-1:0]  gain_reg [NUM_GAINS] = '{default: '0};
   logic signed [INTEG_BITS-1:0]  integ_acc = '0;
   logic signed [SAMPLE_BITS:0]   last_err  = '0;

   pid_word_type     pending_words [$];
   drive_result_type drive_expect_q [$];
   int               mismatch_count = 0;

   logic no_idle = 1'b0;
   logic hold_go = 1'b0;

   // stimulus shaping: windup runs push the integral into saturation, then reverse
   logic   gen_up      = 1'b1;
   longint gen_sum     = 0;
   int     gen_sat_run = 0;

   task automatic report_mismatch(input string what);
      if (mismatch_count < MAX_PRINTED)
         $display("mismatch at %0t ns: %s", $time, what);
      mismatch_count++;
   endtask

   function automatic drive_result_type predict_drive(input logic signed [SAMPLE_BITS-1:0] tgt,
                                                      input logic signed [SAMPLE_BITS-1:0] mea,
                                                      input logic [TICK_WIDTH-1:0] ticks_in);
      drive_result_type    res;
      logic signed [127:0] err, ticks, sum, deriv, acc, hi_lim, lo_lim;
      res.clipped = 1'b0;
      ticks = (ticks_in == '0) ? 128'sd1 : 128'(ticks_in);
      err   = tgt - mea;

      hi_lim = (128'sd1 <<< (INTEG_BITS - 1)) - 128'sd1;
      lo_lim = -hi_lim - 128'sd1;
      sum = integ_acc + err * ticks;
      if (sum > hi_lim) begin
         sum = hi_lim;
         res.clipped = 1'b1;
      end else if (sum < lo_lim) begin
         sum = lo_lim;
         res.clipped = 1'b1;
      end

      deriv = ((err - last_err) <<< FRAC_BITS) / ticks;
      acc = (gain_reg[REG_P_GAIN] * err + gain_reg[REG_I_GAIN] * sum
             + ((gain_reg[REG_D_GAIN] * deriv) >>> FRAC_BITS)) >>> FRAC_BITS;

      hi_lim = (128'sd1 <<< (DRIVE_WIDTH - 1)) - 128'sd1;
      lo_lim = -hi_lim - 128'sd1;
      if (acc > hi_lim) begin
         acc = hi_lim;
         res.clipped = 1'b1;
      end else if (acc < lo_lim) begin
         acc = lo_lim;
         res.clipped = 1'b1;
      end

      res.drive = acc[DRIVE_WIDTH-1:0];
      integ_acc = sum[INTEG_BITS-1:0];
      last_err  = err[SAMPLE_BITS:0];
      return res;
   endfunction

   function automatic pid_word_type pick_random_word();
      pid_word_type                  w;
      int unsigned                   kind;
      logic signed [SAMPLE_BITS-1:0] big;
      longint                        sat_lim;
      kind = $urandom_range(99);
      if (kind < 75) begin
         big        = SAMPLE_BITS'(32767 - $urandom_range(2000));
         w.target   = gen_up ? big : ~big;
         w.measured = gen_up ? ~big : big;
         w.ticks    = TICK_WIDTH'($urandom_range(65535, 50000));
      end else if (kind < 88) begin
         w.target   = SAMPLE_BITS'($signed($urandom_range(600)) - 300);
         w.measured = SAMPLE_BITS'($signed($urandom_range(600)) - 300);
         w.ticks    = TICK_WIDTH'($urandom_range(8));
      end else begin
         w.target   = SAMPLE_BITS'($urandom);
         w.measured = SAMPLE_BITS'($urandom);
         w.ticks    = TICK_WIDTH'($urandom);
      end

      sat_lim = longint'(1) <<< (INTEG_BITS - 1);
      gen_sum += (longint'(w.target) - longint'(w.measured)) * longint'(w.ticks);
      if (gen_sum >= sat_lim) gen_sum = sat_lim;
      if (gen_sum <= -sat_lim) gen_sum = -sat_lim;
      if ((gen_up && gen_sum >= sat_lim) || (!gen_up && gen_sum <= -sat_lim)) begin
         gen_sat_run++;
         if (gen_sat_run > SAT_RUN_LEN) begin
            gen_up      = !gen_up;
            gen_sat_run = 0;
         end
      end
      return w;
   endfunction

   always @(posedge clock) begin : req_driver
      pid_word_type     next_word;
      drive_result_type next_rsp;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            next_rsp       = predict_drive(req_target, req_measured, req_elapsed_ticks);
            drive_expect_q = {drive_expect_q, next_rsp};
         end
         if (!req_valid || req_ready) begin
            if (pending_words.size() != 0
                && (no_idle || $urandom_range(99) >= IDLE_PERCENT)) begin
               next_word = pending_words.pop_front();
               req_valid         <= 1'b1;
               req_target        <= next_word.target;
               req_measured      <= next_word.measured;
               req_elapsed_ticks <= next_word.ticks;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : rsp_monitor
      drive_result_type want;
      int               hold_left;
      logic             hold_armed;
      if (reset) begin
         rsp_ready  <= 1'b0;
         hold_left  = 0;
         hold_armed = 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (drive_expect_q.size() == 0) begin
               report_mismatch($sformatf("unexpected result word drive %0d", rsp_drive));
            end else begin
               want = drive_expect_q.pop_front();
               if (rsp_drive !== want.drive)
                  report_mismatch($sformatf("drive %0d, predicted %0d", rsp_drive, want.drive));
               if (rsp_clipped !== want.clipped)
                  report_mismatch($sformatf("clipped %b, predicted %b", rsp_clipped,
                                            want.clipped));
            end
         end
         if (hold_go && !hold_armed) begin
            hold_armed = 1'b1;
            hold_left  = RSP_HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
         end
      end
   end

   task automatic csr_write(input logic [CSR_ADDR_WIDTH-1:0] addr,
                            input logic [CSR_DATA_WIDTH-1:0] data);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic csr_read(input logic [CSR_ADDR_WIDTH-1:0] addr,
                           output logic [CSR_DATA_WIDTH-1:0] data);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= addr;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      data = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic check_gain_readback();
      logic [CSR_DATA_WIDTH-1:0] rd;
      csr_reg_type               r;
      for (int n = 0; n < NUM_GAINS; n++) begin
         r = csr_reg_type'(n);
         csr_read({r, 2'b00}, rd);
         if (rd !== {{(CSR_DATA_WIDTH-GAIN_WIDTH){1'b0}}, gain_reg[r]})
            report_mismatch($sformatf("%s reads %h", r.name(), rd));
      end
   endtask

   task automatic load_gains(input logic signed [GAIN_WIDTH-1:0] kp,
                             input logic signed [GAIN_WIDTH-1:0] ki,
                             input logic signed [GAIN_WIDTH-1:0] kd);
      logic signed [GAIN_WIDTH-1:0] vals [NUM_GAINS];
      csr_reg_type                  r;
      vals = '{kp, ki, kd};
      for (int n = 0; n < NUM_GAINS; n++) begin
         r = csr_reg_type'(n);
         csr_write({r, 2'b00}, {(CSR_DATA_WIDTH-GAIN_WIDTH)'($urandom), vals[n]});
         gain_reg[r] = vals[n];
      end
      check_gain_readback();
   endtask

   task automatic queue_word(input int tgt, input int mea, input int ticks);
      pid_word_type w;
      w.target      = SAMPLE_BITS'(tgt);
      w.measured    = SAMPLE_BITS'(mea);
      w.ticks       = TICK_WIDTH'(ticks);
      pending_words = {pending_words, w};
   endtask

   // checked between edges so that queue and valid updates have settled
   task automatic wait_drained();
      while (pending_words.size() != 0 || req_valid || drive_expect_q.size() != 0)
         @(negedge clock);
      repeat (4) @(posedge clock);
   endtask

   initial begin : stimulus
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: field extremes, zero ticks, derivative rounding
      load_gains(16'sd256, 16'sd16, 16'sd512);
      queue_word(0, 0, 1);
      queue_word(32767, -32768, 65535);
      queue_word(-32768, 32767, 65535);
      queue_word(32767, -32768, 0);
      queue_word(-32768, 32767, 1);
      queue_word(100, 50, 0);
      queue_word(0, 0, 3);
      queue_word(-1, 0, 7);
      queue_word(1, 0, 7);
      queue_word(32767, 32767, 65535);
      queue_word(-32768, -32768, 1);
      queue_word(21845, -21846, 16'hAAAA);
      queue_word(-21846, 21845, 16'h5555);
      queue_word(-5, 3, 2);
      wait_drained();

      // full-scale gains drive the output into saturation
      load_gains(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
      queue_word(32767, -32768, 65535);
      queue_word(32767, -32768, 65535);
      queue_word(-32768, 32767, 1);
      queue_word(0, 0, 0);
      wait_drained();

      // write to an unmapped register is ignored
      csr_write(SPARE_ADDR, $urandom);
      check_gain_readback();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: load_gains(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
            1: load_gains(-16'sh8000, -16'sh8000, -16'sh8000);
            2: load_gains(16'sh7FFF, -16'sh8000, 16'sh0000);
            default: load_gains(GAIN_WIDTH'($urandom), GAIN_WIDTH'($urandom),
                                GAIN_WIDTH'($urandom));
         endcase
         no_idle <= (phase == 3);
         if (phase == 1)
            hold_go <= 1'b1;
         repeat (WORDS_PER_PHASE) pending_words = {pending_words, pick_random_word()};
         wait_drained();
      end

      no_idle <= 1'b0;
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("status: fail");
      $finish;
   end

endmodule
